// File: rtl/core/ncm_pkg.sv
// ----------------------------------------------------------------------------
// ncm_pkg
// Shared constants and types for the nearest centroid cosine matcher.
// ----------------------------------------------------------------------------
package ncm_pkg;

  localparam int unsigned DIM_DEF         = 512;
  localparam int unsigned MAX_CLASSES_DEF = 32;
  localparam int unsigned ACC_WIDTH_DEF   = 32;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned CLASS_W = 5;
  localparam int unsigned DIMI_W  = 9;
  localparam int unsigned ELEM_W  = 16;
  localparam int unsigned NCLS_W  = 6;
  localparam logic [NCLS_W-1:0] NCLS_RESET = 6'd32;

  localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PROBE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPARE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [CLASS_W-1:0]       class_id;
    logic [DIMI_W-1:0]        dim_index;
    logic signed [ELEM_W-1:0] elem_value;
  } req_t;

  typedef struct packed {
    logic [CLASS_W-1:0]       scored_class;
    logic signed [ELEM_W-1:0] class_score;
    logic [CLASS_W-1:0]       best_class;
    logic signed [ELEM_W-1:0] best_score;
    logic                     last;
  } rsp_t;

  // divider / square root job between the sequencer and the shared unit
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [63:0] num;
    logic [31:0] den;
  } div_cmd_t;

endpackage

// File: rtl/core/ncm_stream_if.sv
// ----------------------------------------------------------------------------
// ncm_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface ncm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/ncm_divsqrt.sv
// ----------------------------------------------------------------------------
// ncm_divsqrt
// Shared bit-serial unit: restoring integer square root of a 64-bit value
// or 64 by 32 bit unsigned division, one result bit per cycle.
// ----------------------------------------------------------------------------
module ncm_divsqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ncm_pkg::div_cmd_t  cmd_i,
  output logic               done_o,
  output logic [63:0]        res_o
);

  logic        busy_q, busy_d;
  logic        sqrt_q, sqrt_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] x_q, x_d;
  logic [65:0] rem_q, rem_d;
  logic [63:0] res_q, res_d;
  logic [31:0] den_q, den_d;
  logic        done_q, done_d;
  logic [65:0] trial;
  logic [65:0] rsh;

  always_comb begin
    busy_d = busy_q;
    sqrt_d = sqrt_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    rem_d  = rem_q;
    res_d  = res_q;
    den_d  = den_q;
    done_d = 1'b0;
    trial  = '0;
    rsh    = '0;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      sqrt_d = cmd_i.is_sqrt;
      cnt_d  = cmd_i.is_sqrt ? 7'd32 : 7'd64;
      x_d    = cmd_i.num;
      rem_d  = '0;
      res_d  = '0;
      den_d  = cmd_i.den;
    end else if (busy_q) begin
      if (sqrt_q) begin
        rsh   = {rem_q[63:0], x_q[63:62]};
        trial = {res_q[63:0], 2'b01};
        x_d   = {x_q[61:0], 2'b00};
        if (rsh >= trial) begin
          rem_d = rsh - trial;
          res_d = {res_q[62:0], 1'b1};
        end else begin
          rem_d = rsh;
          res_d = {res_q[62:0], 1'b0};
        end
      end else begin
        rsh   = {rem_q[64:0], x_q[63]};
        trial = {34'd0, den_q};
        x_d   = {x_q[62:0], 1'b0};
        if (rsh >= trial) begin
          rem_d = rsh - trial;
          res_d = {res_q[62:0], 1'b1};
        end else begin
          rem_d = rsh;
          res_d = {res_q[62:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sqrt_q <= sqrt_d;
    x_q    <= x_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: rtl/core/nearest_centroid_cosine_match.sv
// ----------------------------------------------------------------------------
// nearest_centroid_cosine_match
// Per-class centroid accumulation and cosine-score nearest class search.
// ----------------------------------------------------------------------------
// in_if carries commands: add gallery element, load probe element, compare,
// clear. out_if carries one result per class walked on compare, each with the
// running best; last marks the final one. cfg_we_i/cfg_wdata_i set the number
// of classes walked (limited to MAX_CLASSES and 32).
// An add reads the memory, adds with saturation and writes back; a probe load
// writes one probe element. A compare walks each class: a pass over DIM
// elements in the centroid memory for the peak magnitude, a shift search,
// then one multiply-accumulate pass for dot product and norm (one element per
// cycle in each pass), then a square root and a division in the shared
// bit-serial unit. A class with an all-zero centroid ends after the peak pass.
// A clear sweeps all MAX_CLASSES*DIM words of the centroid memory.
// After reset the same sweep zeroes the centroid memory; no command is
// accepted meanwhile. Results are held in an output register; when the
// receiver stalls the walk waits for the transfer.
// ----------------------------------------------------------------------------
module nearest_centroid_cosine_match #(
  parameter int unsigned DIM         = ncm_pkg::DIM_DEF,
  parameter int unsigned MAX_CLASSES = ncm_pkg::MAX_CLASSES_DEF,
  parameter int unsigned ACC_WIDTH   = ncm_pkg::ACC_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ncm_pkg::NCLS_W-1:0]   cfg_wdata_i,
  ncm_stream_if.sink                   in_if,
  ncm_stream_if.source                 out_if
);

  localparam int unsigned DW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned CW    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int unsigned DEPTH = DIM * MAX_CLASSES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NLIM  = (MAX_CLASSES < 32) ? MAX_CLASSES : 32;
  localparam logic signed [ACC_WIDTH-1:0] AMAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] AMIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ADD_RD, S_ADD_WR, S_MAX, S_SHIFT, S_DOT, S_MACW,
    S_SQRT, S_DIV, S_OUT
  } state_e;

  state_e state_q;

  logic signed [ACC_WIDTH-1:0] mem [DEPTH];
  logic signed [15:0]          probe [DIM];
  logic signed [ACC_WIDTH-1:0] rd_q;
  logic signed [15:0]          prd_q;
  logic [AW-1:0]               addr_q;
  logic [AW:0]                 clr_cnt_q;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic signed [ACC_WIDTH-1:0] wdata;

  logic [ncm_pkg::NCLS_W-1:0] ncls_q;
  logic [5:0]                 nwalk_q;
  logic [CW-1:0]              cls_q;
  logic [DW:0]                d_q;
  logic                       rdv_q;
  logic signed [15:0]         val_q;
  logic [ACC_WIDTH-1:0]       m_q;
  logic [6:0]                 sh_q;
  logic                       shr_q;
  logic signed [63:0]         dot_q;
  logic [63:0]                nsq_q;
  logic [63:0]                q_q;
  logic [ncm_pkg::CLASS_W-1:0] best_c_q;
  logic signed [15:0]          best_s_q;
  logic                        ovalid_q;
  logic                        out_load;
  ncm_pkg::rsp_t               out_q;
  ncm_pkg::div_cmd_t           dcmd;
  logic                        ddone;
  logic [63:0]                 dres;

  // magnitude of current read, shifted
  logic [ACC_WIDTH-1:0] mag;
  logic [63:0]          amag;
  logic signed [16:0]   sval;
  logic signed [32:0]   prod;
  logic [29:0]          sq;
  logic signed [ACC_WIDTH:0] sum;
  logic signed [15:0]   score;
  logic [AW-1:0]        caddr;

  assign mag  = rd_q[ACC_WIDTH-1] ? ACC_WIDTH'(-rd_q) : rd_q;
  assign amag = shr_q ? (64'(mag) >> sh_q) : (64'(mag) << sh_q);
  assign sval = rd_q[ACC_WIDTH-1] ? -$signed({1'b0, amag[15:0]}) :
                $signed({1'b0, amag[15:0]});
  assign prod = prd_q * sval;
  assign sq   = amag[14:0] * amag[14:0];
  assign sum  = $signed({rd_q[ACC_WIDTH-1], rd_q}) + (ACC_WIDTH+1)'(val_q);
  assign caddr = AW'(cls_q) * AW'(DIM) + AW'(d_q[DW-1:0]);
  assign out_load = (state_q == S_OUT) && (!ovalid_q || out_if.ready);

  always_comb begin
    if (dot_q[63]) score = (q_q > 64'd32768) ? 16'sh8000 : 16'(-q_q);
    else score = (q_q > 64'd32767) ? 16'sh7fff : q_q[15:0];
  end

  ncm_divsqrt u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (dcmd),
    .done_o (ddone),
    .res_o  (dres)
  );

  always_comb begin
    dcmd = '0;
    we   = 1'b0;
    waddr = addr_q;
    wdata = '0;
    if (state_q == S_CLR) begin
      we = 1'b1;
      waddr = clr_cnt_q[AW-1:0];
    end else if (state_q == S_ADD_WR) begin
      we = 1'b1;
      wdata = (sum > $signed({AMAX[ACC_WIDTH-1], AMAX})) ? AMAX :
              (sum < $signed({AMIN[ACC_WIDTH-1], AMIN})) ? AMIN :
              sum[ACC_WIDTH-1:0];
    end
    if (state_q == S_MACW && !rdv_q && 32'(d_q) >= DIM) begin
      dcmd.start   = 1'b1;
      dcmd.is_sqrt = 1'b1;
      dcmd.num     = nsq_q;
    end else if (state_q == S_SQRT && ddone && dres != 64'd0) begin
      dcmd.start = 1'b1;
      dcmd.num   = dot_q[63] ? 64'(-dot_q) : 64'(dot_q);
      dcmd.den   = dres[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q  <= mem[(state_q == S_ADD_RD) ? addr_q : caddr];
    prd_q <= probe[d_q[DW-1:0]];
    if (state_q == S_IDLE && in_if.valid && in_if.data.func == ncm_pkg::FUNC_PROBE &&
        32'(in_if.data.dim_index) < DIM)
      probe[in_if.data.dim_index[DW-1:0]] <= in_if.data.elem_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_cnt_q <= '0;
      ncls_q    <= ncm_pkg::NCLS_RESET;
      ovalid_q  <= 1'b0;
      best_c_q  <= '0;
      best_s_q  <= 16'sh8000;
      cls_q     <= '0;
      d_q       <= '0;
      rdv_q     <= 1'b0;
      nwalk_q   <= '0;
      addr_q    <= '0;
    end else begin
      if (cfg_we_i) ncls_q <= cfg_wdata_i;
      if (out_load) ovalid_q <= 1'b1;
      else if (out_if.ready) ovalid_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == (AW+1)'(DEPTH - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_if.valid) begin
            val_q  <= in_if.data.elem_value;
            addr_q <= AW'(in_if.data.class_id) * AW'(DIM) + AW'(in_if.data.dim_index);
            case (in_if.data.func)
              ncm_pkg::FUNC_ADD: begin
                if (32'(in_if.data.class_id) < MAX_CLASSES &&
                    32'(in_if.data.dim_index) < DIM) state_q <= S_ADD_RD;
              end
              ncm_pkg::FUNC_CLEAR: begin
                clr_cnt_q <= '0;
                state_q   <= S_CLR;
              end
              ncm_pkg::FUNC_COMPARE: begin
                best_c_q <= '0;
                best_s_q <= 16'sh8000;
                nwalk_q  <= (32'(ncls_q) > NLIM) ? 6'(NLIM) : ncls_q;
                cls_q    <= '0;
                if (ncls_q != '0) begin
                  state_q <= S_MAX;
                  d_q     <= '0;
                  rdv_q   <= 1'b0;
                  m_q     <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_ADD_RD: state_q <= S_ADD_WR;
        S_ADD_WR: state_q <= S_IDLE;
        S_MAX: begin
          if (rdv_q && mag > m_q) m_q <= mag;
          rdv_q <= (32'(d_q) < DIM);
          if (32'(d_q) < DIM) d_q <= d_q + 1'b1;
          else if (rdv_q) begin
            state_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // zero peak scores 0; else set up the shift search, one step per cycle in S_DOT until m lands in [2^14, 2^15)
          if (m_q == '0) begin
            q_q     <= '0;
            dot_q   <= '0;
            state_q <= S_OUT;
          end else begin
            sh_q  <= '0;
            shr_q <= (m_q >= ACC_WIDTH'(32768));
            d_q   <= '0;
            rdv_q <= 1'b0;
            dot_q <= '0;
            nsq_q <= '0;
            state_q <= S_DOT;
          end
        end
        S_DOT: begin
          if ((shr_q && (64'(m_q) >> sh_q) >= 64'd32768) ||
              (!shr_q && (64'(m_q) << sh_q) < 64'd16384)) sh_q <= sh_q + 1'b1;
          else state_q <= S_MACW;
        end
        S_MACW: begin
          if (rdv_q) begin
            dot_q <= dot_q + 64'(prod);
            nsq_q <= nsq_q + 64'(sq);
          end
          rdv_q <= (32'(d_q) < DIM);
          if (32'(d_q) < DIM) d_q <= d_q + 1'b1;
          else if (!rdv_q) state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (ddone) begin
            if (dres == 64'd0) begin
              q_q     <= '0;
              dot_q   <= '0;
              state_q <= S_OUT;
            end else state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (ddone) begin
            q_q     <= dres;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_q.scored_class <= ncm_pkg::CLASS_W'(cls_q);
            out_q.class_score  <= score;
            out_q.last <= (6'(cls_q) + 6'd1 == nwalk_q);
            if (cls_q == '0 || score > best_s_q) begin
              best_s_q <= score; best_c_q <= ncm_pkg::CLASS_W'(cls_q);
              out_q.best_class <= ncm_pkg::CLASS_W'(cls_q);
              out_q.best_score <= score;
            end else begin
              out_q.best_class <= best_c_q;
              out_q.best_score <= best_s_q;
            end
            if (6'(cls_q) + 6'd1 == nwalk_q) state_q <= S_IDLE;
            else begin
              cls_q <= cls_q + 1'b1;
              d_q <= '0; rdv_q <= 1'b0; m_q <= '0;
              state_q <= S_MAX;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_if.ready  = (state_q == S_IDLE);
  assign out_if.valid = ovalid_q;
  assign out_if.data  = out_q;

endmodule
